/* rtl/core/kmcc_pkg.sv */
// Shared types, codes and widths of the k-means centroid combiner.
package kmcc_pkg;

  localparam int INDEX_BITS = 6;
  localparam int COORD_BITS = 16;
  localparam int COUNT_BITS = 32;
  localparam int DIST_BITS  = 32;
  localparam int SUM_BITS   = 48;
  localparam int STEP_BITS  = $clog2(SUM_BITS);

  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_FINISH     = 1'b1;

  typedef struct packed {
    logic                  operation;
    logic [INDEX_BITS-1:0] cluster_index;
    logic [DIST_BITS-1:0]  distance_term;
    logic [COORD_BITS-1:0] coord_0;
    logic [COORD_BITS-1:0] coord_1;
    logic [COORD_BITS-1:0] coord_2;
  } kmcc_item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] centre_index;
    logic [COORD_BITS-1:0] centre_0;
    logic [COORD_BITS-1:0] centre_1;
    logic [COORD_BITS-1:0] centre_2;
    logic [DIST_BITS-1:0]  distortion_total;
    logic                  last;
  } kmcc_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_FIN_RD,
    ST_FIN_LOAD,
    ST_FIN_DIV,
    ST_FIN_EMIT
  } kmcc_state_t;

endpackage

/* rtl/core/kmeans_centroid_combiner.sv */
// Top level of the k-means centroid combiner: accumulator memory and finish sequencer.
//
//   channel   ports                         direction  transaction taken when
//   ------    ----------------------------  ---------  -------------------------------
//   item      start, busy, item             in         start high and busy low
//   result    strobe, result                out        every cycle strobe is high
//   config    cfg_write, cfg_data           in         cfg_write high
//
// An accumulate transaction reads the cluster row as it is taken, then adds the
// point and writes that row back in the ST_ACC state.
// A finish transaction walks clusters 0..top (top = last_cluster capped at
// CLUSTERS-1); per cluster: row read, divider load, a one-bit-per-cycle
// restoring divider (one lane per dimension), and emit.
// Each result is registered and shown behind a strobe high for a single cycle;
// the receiver cannot stall, so nothing ever backs up.
// Reset clears the per-row valid flags at once, so the accumulators read as
// zero right away with no clearing pass; a finish clears them the same way.
module kmeans_centroid_combiner
  import kmcc_pkg::*;
#(
  parameter int CLUSTERS = 64,
  parameter int DIMS     = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  kmcc_item_t            item,
  output logic                  strobe,
  output kmcc_result_t          result,
  input  logic                  cfg_write,
  input  logic [INDEX_BITS-1:0] cfg_data
);

  localparam int CW = $clog2(CLUSTERS);

  // One memory row holds everything a cluster owns.
  typedef struct packed {
    logic [DIMS-1:0][SUM_BITS-1:0] sums;
    logic [DIST_BITS-1:0]          distortion;
    logic [COUNT_BITS-1:0]         count;
  } row_t;

  kmcc_state_t state, state_next;

  logic [INDEX_BITS-1:0] last_cluster;
  kmcc_item_t            item_q;
  logic                  accept;
  logic                  index_ok;
  logic [CW-1:0]         top;
  logic [CW-1:0]         clus;
  logic [DIST_BITS-1:0]  total;

  // Accumulator memory and its valid flags.
  row_t                  mem [CLUSTERS];
  logic [CLUSTERS-1:0]   row_valid;
  logic [CW-1:0]         rd_addr;
  logic [CW-1:0]         wr_addr;
  logic                  mem_we;
  row_t                  rd_row;
  logic                  rd_valid;
  row_t                  row;
  row_t                  acc_row;
  logic [COORD_BITS-1:0] coords [3];

  // Divider lanes, one per dimension, sharing the divisor.
  logic [COUNT_BITS-1:0] divisor;
  logic [SUM_BITS-1:0]   lane_dvd [DIMS];
  logic [COUNT_BITS-1:0] lane_rem [DIMS];
  logic                  lane_neg [DIMS];
  logic [COUNT_BITS:0]   trial    [DIMS];
  logic [COUNT_BITS:0]   diff     [DIMS];
  logic                  ge       [DIMS];
  logic [STEP_BITS-1:0]  step;
  logic [COORD_BITS-1:0] quot     [3];
  logic                  last_row;

  assign accept   = start && !busy;
  assign index_ok = {1'b0, item.cluster_index} < 7'(CLUSTERS);
  assign top      = ({1'b0, last_cluster} > 7'(CLUSTERS - 1)) ? CW'(CLUSTERS - 1)
                                                              : last_cluster[CW-1:0];
  assign last_row = (clus == top);
  assign wr_addr  = item_q.cluster_index[CW-1:0];

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item.operation == OP_FINISH) begin
            state_next = ST_FIN_RD;
          end else if (index_ok) begin
            state_next = ST_ACC;
          end
        end
      end
      ST_ACC:      state_next = ST_IDLE;
      ST_FIN_RD:   state_next = ST_FIN_LOAD;
      ST_FIN_LOAD: state_next = ST_FIN_DIV;
      ST_FIN_DIV: begin
        if (step == STEP_BITS'(SUM_BITS - 1)) begin
          state_next = ST_FIN_EMIT;
        end
      end
      ST_FIN_EMIT: state_next = last_row ? ST_IDLE : ST_FIN_RD;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = (state != ST_IDLE);
    mem_we  = (state == ST_ACC);
    // In idle, read the row that an incoming point would hit.
    rd_addr = (state == ST_IDLE) ? item.cluster_index[CW-1:0] : clus;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      last_cluster <= '0;
      clus         <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        last_cluster <= cfg_data;
      end
      if (accept) begin
        clus <= '0;
      end else if (state == ST_FIN_EMIT && !last_row) begin
        clus <= clus + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Memory: one write port, one registered read port
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= acc_row;
    end
    rd_row <= mem[rd_addr];
  end

  // A row never written since reset or the last finish reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= row_valid[rd_addr];
      if (mem_we) begin
        row_valid[wr_addr] <= 1'b1;
      end else if (state == ST_FIN_EMIT && last_row) begin
        row_valid <= '0;
      end
    end
  end

  assign row = rd_valid ? rd_row : '0;

  // ---------------------------------------------------------------------
  // Accumulate: add the held point into the row just read
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
  end

  always_comb begin
    coords[0] = item_q.coord_0;
    coords[1] = item_q.coord_1;
    coords[2] = item_q.coord_2;
    acc_row.count      = row.count + COUNT_BITS'(1);
    acc_row.distortion = row.distortion + item_q.distance_term;
    for (int d = 0; d < DIMS; d++) begin
      acc_row.sums[d] = row.sums[d]
                      + {{(SUM_BITS - COORD_BITS){coords[d][COORD_BITS-1]}}, coords[d]};
    end
  end

  // ---------------------------------------------------------------------
  // Finish: restoring divide of |sum| by count, one quotient bit per cycle
  // ---------------------------------------------------------------------
  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      trial[d] = {lane_rem[d], lane_dvd[d][SUM_BITS-1]};
      diff[d]  = trial[d] - {1'b0, divisor};
      ge[d]    = (trial[d] >= {1'b0, divisor});
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      total <= '0;
    end
    if (state == ST_FIN_LOAD) begin
      divisor <= (row.count == '0) ? COUNT_BITS'(1) : row.count;
      total   <= total + row.distortion;
      step    <= '0;
      for (int d = 0; d < DIMS; d++) begin
        lane_neg[d] <= row.sums[d][SUM_BITS-1];
        lane_dvd[d] <= row.sums[d][SUM_BITS-1] ? (~row.sums[d] + 1'b1) : row.sums[d];
        lane_rem[d] <= '0;
      end
    end else if (state == ST_FIN_DIV) begin
      step <= step + 1'b1;
      for (int d = 0; d < DIMS; d++) begin
        lane_rem[d] <= ge[d] ? diff[d][COUNT_BITS-1:0] : trial[d][COUNT_BITS-1:0];
        lane_dvd[d] <= {lane_dvd[d][SUM_BITS-2:0], ge[d]};
      end
    end
  end

  // Keep the low quotient bits and restore the sign; unused dimensions stay zero.
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      quot[d] = '0;
    end
    for (int d = 0; d < DIMS; d++) begin
      quot[d] = lane_neg[d] ? (~lane_dvd[d][COORD_BITS-1:0] + 1'b1)
                            : lane_dvd[d][COORD_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (state == ST_FIN_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN_EMIT) begin
      result.centre_index     <= INDEX_BITS'(clus);
      result.centre_0         <= quot[0];
      result.centre_1         <= quot[1];
      result.centre_2         <= quot[2];
      result.distortion_total <= last_row ? total : '0;
      result.last             <= last_row;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_strobe_from_emit: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state) == ST_FIN_EMIT)
    else $error("result strobe without an emit step");

  a_strobe_isolated: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("two results on back-to-back cycles");

  a_finish_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && item.operation == OP_FINISH) |=> busy)
    else $error("finish transaction did not start the sequencer");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN_DIV) |-> divisor != '0)
    else $error("divider running with a zero divisor");

endmodule
